### sv/count_ordered_lookup_table_defines.svh
// Assertion macros shared by the table controller and datapath.
// Each takes a label, the clock, the reset and the property parts.
`ifndef COUNT_ORDERED_LOOKUP_TABLE_DEFINES_SVH
`define COUNT_ORDERED_LOOKUP_TABLE_DEFINES_SVH

`ifndef ASSERT_OFF
`define COLT_ASSERT(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (prop)) else $error(msg);
`define COLT_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) else $error(msg);
`define COLT_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) else $error(msg);
`else
`define COLT_ASSERT(lbl, clk_s, rst_s, prop, msg)
`define COLT_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons, msg)
`define COLT_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons, msg)
`endif

`endif

### sv/colt_pkg.sv
`timescale 1ns / 1ps

package colt_pkg;

  // Default sizes of the table.
  localparam int DEPTH_DEF      = 16;
  localparam int KEY_BITS_DEF   = 32;
  localparam int COUNT_BITS_DEF = 16;

  // Request codes.
  localparam logic [2:0] OP_APPEND = 3'd0;
  localparam logic [2:0] OP_LOOKUP = 3'd1;
  localparam logic [2:0] OP_EXISTS = 3'd2;
  localparam logic [2:0] OP_GET    = 3'd3;
  localparam logic [2:0] OP_DELETE = 3'd4;

  // Status codes.
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  // One request beat.
  typedef struct packed {
    logic [2:0]  req_type;
    logic [31:0] item_key;
    logic [15:0] item_length;
    logic [3:0]  entry_index;
  } colt_req_t;

  // One result beat.
  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  found_index;
    logic [31:0] key_out;
    logic [15:0] length_out;
    logic [4:0]  entry_count;
  } colt_rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic execute;
  } colt_cmd_t;

endpackage

### sv/count_ordered_lookup_table.sv
`timescale 1ns / 1ps

// Ordered lookup table with hit-count promotion.
// Request channel: a beat is taken at a rising edge where start is high and
// busy is low. req carries the request type, key, length and entry index.
// Result channel: done is high for exactly one cycle with the result beat on
// rsp; the receiver cannot stall it, so it must take the beat that cycle.
// The request is compared against all slots in parallel and the match vector
// is registered at the accepting edge; then, with busy high, the block applies
// the append, promotion swap, delete shift or read to the slot registers and
// registers the result, which shows on rsp with done. busy is high only during
// that update, so a new request can be taken in the same cycle as the previous
// result is shown.
// Reset empties the table (entry count zero) and returns the controller to
// idle; slot contents are left as they are and are never read until
// written.
module count_ordered_lookup_table #(
  parameter int DEPTH      = colt_pkg::DEPTH_DEF,
  parameter int KEY_BITS   = colt_pkg::KEY_BITS_DEF,
  parameter int COUNT_BITS = colt_pkg::COUNT_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  colt_pkg::colt_req_t req,
  output logic                done,
  output colt_pkg::colt_rsp_t rsp
);
  import colt_pkg::*;

  colt_cmd_t cmd;

  // Sequencing of capture and update.
  colt_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  // Slot registers, compare row and result register.
  colt_dp #(
    .DEPTH      (DEPTH),
    .KEY_BITS   (KEY_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .req (req),
    .rsp (rsp)
  );

endmodule

### sv/colt_ctrl.sv
`timescale 1ns / 1ps
`include "count_ordered_lookup_table_defines.svh"

module colt_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  output logic                done,
  output colt_pkg::colt_cmd_t cmd
);
  import colt_pkg::*;

  typedef enum logic {S_IDLE, S_EXEC} state_t;

  state_t state;

  // Capture on an accepted beat, update the table in the following cycle.
  assign busy        = (state == S_EXEC);
  assign cmd.capture = start && (state == S_IDLE);
  assign cmd.execute = (state == S_EXEC);

  // State and the result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= (state == S_EXEC);
      unique case (state)
        S_IDLE: begin
          if (start) state <= S_EXEC;
        end
        S_EXEC: begin
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `COLT_ASSERT_NXT(a_done_after_exec, clk, rst, state == S_EXEC, done, "no result after update")
  `COLT_ASSERT_NXT(a_busy_after_capture, clk, rst, cmd.capture, busy, "capture without busy")
  `COLT_ASSERT_NXT(a_busy_single, clk, rst, busy, !busy, "busy held for two cycles")
  `COLT_ASSERT_IMP(a_done_idle, clk, rst, done, !busy, "result while busy")

endmodule

### sv/colt_dp.sv
`timescale 1ns / 1ps
`include "count_ordered_lookup_table_defines.svh"

module colt_dp #(
  parameter int DEPTH      = colt_pkg::DEPTH_DEF,
  parameter int KEY_BITS   = colt_pkg::KEY_BITS_DEF,
  parameter int COUNT_BITS = colt_pkg::COUNT_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  colt_pkg::colt_cmd_t cmd,
  input  colt_pkg::colt_req_t req,
  output colt_pkg::colt_rsp_t rsp
);
  import colt_pkg::*;

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > 4) ? CNT_W : 4;

  // Table slots, kept in order; only slots below valid_count are live.
  logic [KEY_BITS-1:0]   key_q [DEPTH];
  logic [15:0]           len_q [DEPTH];
  logic [COUNT_BITS-1:0] cnt_q [DEPTH];
  logic [COUNT_BITS-1:0] inc   [DEPTH];
  logic [CNT_W-1:0]      valid_count;

  colt_req_t             req_q;
  logic [DEPTH-1:0]      hit_q;
  logic [DEPTH-1:0]      hit;
  logic [DEPTH-1:0]      first_sel;
  logic [DEPTH-1:0]      swap;
  logic [IDX_W-1:0]      found_pos;
  logic [IDX_W-1:0]      idx_sel;
  logic                  idx_ok;
  logic                  full;
  logic [CNT_W-1:0]      count_next;
  colt_rsp_t             rsp_next;
  colt_rsp_t             rsp_q;

  // Compare the incoming key and length against every live slot at once.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      hit[i] = (key_q[i] == KEY_BITS'(req.item_key)) && (len_q[i] == req.item_length) &&
               (CNT_W'(i) < valid_count);
    end
  end

  // Hold the request and its match vector for the update cycle.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_q <= req;
      hit_q <= hit;
    end
  end

  // The lowest matching slot wins.
  assign first_sel = hit_q & (~hit_q + DEPTH'(1));

  always_comb begin
    found_pos = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (first_sel[i]) found_pos = found_pos | IDX_W'(i);
    end
  end

  assign idx_ok  = CMP_W'(req_q.entry_index) < CMP_W'(valid_count);
  assign idx_sel = IDX_W'(req_q.entry_index);
  assign full    = (valid_count == CNT_W'(DEPTH));

  // Per-slot update logic; each slot sees only its two neighbors.
  for (genvar i = 0; i < DEPTH; i++) begin : g_slot
    localparam int PREV = (i > 0) ? i - 1 : 0;
    localparam int NEXT = (i + 1 < DEPTH) ? i + 1 : i;

    // Saturating hit count increment.
    assign inc[i] = (cnt_q[i] == '1) ? cnt_q[i] : cnt_q[i] + 1'b1;

    // The hit slot moves up when its new count beats its predecessor.
    if (i > 0) begin : g_swap
      assign swap[i] = first_sel[i] && (inc[i] > cnt_q[PREV]);
    end else begin : g_head
      assign swap[i] = 1'b0;
    end

    always_ff @(posedge clk) begin
      if (cmd.execute) begin
        case (req_q.req_type)
          OP_APPEND: begin
            if (!full && (valid_count == CNT_W'(i))) begin
              key_q[i] <= KEY_BITS'(req_q.item_key);
              len_q[i] <= req_q.item_length;
              cnt_q[i] <= '0;
            end
          end
          OP_LOOKUP: begin
            if (swap[i]) begin
              key_q[i] <= key_q[PREV];
              len_q[i] <= len_q[PREV];
              cnt_q[i] <= cnt_q[PREV];
            end else if ((i + 1 < DEPTH) && swap[NEXT]) begin
              key_q[i] <= key_q[NEXT];
              len_q[i] <= len_q[NEXT];
              cnt_q[i] <= inc[NEXT];
            end else if (first_sel[i]) begin
              cnt_q[i] <= inc[i];
            end
          end
          OP_DELETE: begin
            if (idx_ok && (i + 1 < DEPTH) && (IDX_W'(i) >= idx_sel)) begin
              key_q[i] <= key_q[NEXT];
              len_q[i] <= len_q[NEXT];
              cnt_q[i] <= cnt_q[NEXT];
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Result beat and the new entry count.
  always_comb begin
    count_next           = valid_count;
    rsp_next.status      = ST_MISS;
    rsp_next.found_index = '0;
    rsp_next.key_out     = '0;
    rsp_next.length_out  = '0;
    case (req_q.req_type) inside
      OP_APPEND: begin
        if (full) begin
          rsp_next.status = ST_FULL;
        end else begin
          rsp_next.status = ST_OK;
          count_next      = valid_count + 1'b1;
        end
      end
      OP_LOOKUP, OP_EXISTS: begin
        if (|hit_q) begin
          rsp_next.status      = ST_OK;
          rsp_next.found_index = 4'(found_pos);
        end
      end
      OP_GET: begin
        if (idx_ok) begin
          rsp_next.status     = ST_OK;
          rsp_next.key_out    = 32'(key_q[idx_sel]);
          rsp_next.length_out = len_q[idx_sel];
        end
      end
      OP_DELETE: begin
        if (idx_ok) begin
          rsp_next.status = ST_OK;
          count_next      = valid_count - 1'b1;
        end
      end
      default: begin
      end
    endcase
    rsp_next.entry_count = 5'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_count <= '0;
    end else if (cmd.execute) begin
      valid_count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.execute) rsp_q <= rsp_next;
  end

  assign rsp = rsp_q;

  `COLT_ASSERT(a_count_bound, clk, rst, valid_count <= CNT_W'(DEPTH), "entry count above depth")
  `COLT_ASSERT_NXT(a_count_stable, clk, rst, !cmd.execute, $stable(valid_count), "count moved while idle")
  `COLT_ASSERT(a_single_winner, clk, rst, $onehot0(first_sel), "more than one slot selected")

endmodule

### dv/tb_count_ordered_lookup_table.sv
`timescale 1ns / 1ps

module tb_count_ordered_lookup_table;
  import colt_pkg::*;

  localparam int TBL_DEPTH = DEPTH_DEF;
  localparam logic [COUNT_BITS_DEF-1:0] HITS_MAX = '1;

  logic      clk;
  logic      rst;
  logic      start;
  logic      busy;
  logic      done;
  colt_req_t req;
  colt_rsp_t rsp;

  count_ordered_lookup_table dut (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .req  (req),
    .done (done),
    .rsp  (rsp)
  );

  // Predicted table contents, kept in table order.
  logic [31:0]               tbl_key  [TBL_DEPTH];
  logic [15:0]               tbl_len  [TBL_DEPTH];
  logic [COUNT_BITS_DEF-1:0] tbl_hits [TBL_DEPTH];
  int                        tbl_used;

  // Results still owed by the block, oldest first.
  colt_rsp_t rsp_owed_q[$];
  int        err_count;
  int        burst_left;

  // Small pools of keys and lengths so that searches hit often.
  logic [31:0] key_pool [8];
  logic [15:0] len_pool [8];

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard limit on the whole run.
  initial begin
    #10ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Works out the result of one request and updates the predicted table.
  function automatic colt_rsp_t predict_table(colt_req_t r);
    colt_rsp_t                 res;
    int                        pos;
    int                        i;
    logic [31:0]               t_key;
    logic [15:0]               t_len;
    logic [COUNT_BITS_DEF-1:0] t_hits;
    res        = '0;
    res.status = ST_MISS;
    case (r.req_type) inside
      OP_APPEND: begin
        if (tbl_used >= TBL_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          tbl_key[tbl_used]  = r.item_key;
          tbl_len[tbl_used]  = r.item_length;
          tbl_hits[tbl_used] = '0;
          tbl_used++;
          res.status = ST_OK;
        end
      end
      OP_LOOKUP, OP_EXISTS: begin
        pos = -1;
        for (i = 0; i < tbl_used && pos < 0; i++) begin
          if (tbl_key[i] == r.item_key && tbl_len[i] == r.item_length) pos = i;
        end
        if (pos >= 0) begin
          res.status      = ST_OK;
          res.found_index = pos[3:0];
          if (r.req_type == OP_LOOKUP) begin
            if (tbl_hits[pos] != HITS_MAX) tbl_hits[pos]++;
            // Promote past the neighbor only when strictly more popular.
            if (pos > 0 && tbl_hits[pos] > tbl_hits[pos-1]) begin
              t_key  = tbl_key[pos];
              t_len  = tbl_len[pos];
              t_hits = tbl_hits[pos];
              tbl_key[pos]    = tbl_key[pos-1];
              tbl_len[pos]    = tbl_len[pos-1];
              tbl_hits[pos]   = tbl_hits[pos-1];
              tbl_key[pos-1]  = t_key;
              tbl_len[pos-1]  = t_len;
              tbl_hits[pos-1] = t_hits;
            end
          end
        end
      end
      OP_GET: begin
        if (r.entry_index < tbl_used) begin
          res.status     = ST_OK;
          res.key_out    = tbl_key[r.entry_index];
          res.length_out = tbl_len[r.entry_index];
        end
      end
      OP_DELETE: begin
        if (r.entry_index < tbl_used) begin
          for (i = r.entry_index; i + 1 < tbl_used; i++) begin
            tbl_key[i]  = tbl_key[i+1];
            tbl_len[i]  = tbl_len[i+1];
            tbl_hits[i] = tbl_hits[i+1];
          end
          tbl_used--;
          res.status = ST_OK;
        end
      end
      default: begin
        // Unknown request types leave the table alone.
      end
    endcase
    res.entry_count = tbl_used[4:0];
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    err_count++;
  endtask

  // Compare each result beat with the oldest owed result.
  always @(posedge clk) begin
    colt_rsp_t want;
    if (!rst && done) begin
      if (rsp_owed_q.size() == 0) begin
        report_mismatch($sformatf("result beat with nothing owed: %p", rsp));
      end else begin
        want = rsp_owed_q.pop_front();
        if (rsp.status !== want.status)
          report_mismatch($sformatf("status got %0d want %0d", rsp.status, want.status));
        if (rsp.found_index !== want.found_index)
          report_mismatch($sformatf("found_index got %0d want %0d",
                                    rsp.found_index, want.found_index));
        if (rsp.key_out !== want.key_out)
          report_mismatch($sformatf("key_out got %h want %h", rsp.key_out, want.key_out));
        if (rsp.length_out !== want.length_out)
          report_mismatch($sformatf("length_out got %h want %h",
                                    rsp.length_out, want.length_out));
        if (rsp.entry_count !== want.entry_count)
          report_mismatch($sformatf("entry_count got %0d want %0d",
                                    rsp.entry_count, want.entry_count));
      end
    end
  end

  // Offer one request beat and hold it until the block takes it.
  // start is left high so that the next beat can follow at once.
  task automatic send_beat(colt_req_t r);
    req   <= r;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    rsp_owed_q.push_back(predict_table(r));
  endtask

  // Send in bursts of random length with random idle stretches between them.
  task automatic send_paced(colt_req_t r);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap        = $urandom_range(0, 6);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    send_beat(r);
  endtask

  function automatic colt_req_t make_req(logic [2:0] op, logic [31:0] key,
                                         logic [15:0] len, logic [3:0] idx);
    colt_req_t r;
    r.req_type    = op;
    r.item_key    = key;
    r.item_length = len;
    r.entry_index = idx;
    return r;
  endfunction

  // Empty table: every search and every index is out of reach.
  task automatic test_empty_table();
    send_paced(make_req(OP_LOOKUP, 32'h1234_5678, 16'h0042, 4'd0));
    send_paced(make_req(OP_GET, '0, '0, 4'd0));
    send_paced(make_req(3'd7, '1, '1, '1));
  endtask

  // Fill to the last slot with extreme and duplicate entries, then overflow.
  task automatic test_fill_to_full();
    int          i;
    logic [31:0] key;
    logic [15:0] len;
    for (i = 0; i < TBL_DEPTH; i++) begin
      key = $urandom();
      len = 16'($urandom());
      if (i == 0) begin
        key = '0;
        len = '0;
      end else if (i == 1) begin
        key = '1;
        len = '1;
      end else if (i == 4) begin
        // Same key as slot 2 but another length, so it must not match.
        key = tbl_key[2];
        len = tbl_len[2] ^ 16'h0001;
      end else if (i == 9) begin
        // Exact copy of slot 2; searches must stop at the first one.
        key = tbl_key[2];
        len = tbl_len[2];
      end
      send_paced(make_req(OP_APPEND, key, len, 4'($urandom())));
    end
    send_paced(make_req(OP_APPEND, 32'hDEAD_BEEF, 16'h0001, '0));
  endtask

  // Hits, promotion, reads and deletes on the full table.
  task automatic test_hits_and_removal();
    send_paced(make_req(OP_LOOKUP, tbl_key[0], tbl_len[0], '0));
    send_paced(make_req(OP_LOOKUP, tbl_key[2], tbl_len[2], '0));
    send_paced(make_req(OP_EXISTS, tbl_key[5], tbl_len[5] + 16'd1, '0));
    send_paced(make_req(OP_EXISTS, tbl_key[5], tbl_len[5], '0));
    send_paced(make_req(OP_GET, '0, '0, 4'd15));
    send_paced(make_req(OP_GET, '0, '0, 4'd0));
    send_paced(make_req(OP_DELETE, '0, '0, 4'd15));
    send_paced(make_req(OP_DELETE, '0, '0, 4'd3));
    send_paced(make_req(OP_GET, '0, '0, 4'd15));
    send_paced(make_req(OP_DELETE, '0, '0, 4'd15));
  endtask

  // Two entries trade places only once the later one is strictly more popular.
  task automatic test_promotion_order();
    logic [31:0] key_a;
    logic [31:0] key_b;
    key_a = $urandom();
    key_b = key_a ^ 32'h8000_0001;
    while (tbl_used > 0) send_beat(make_req(OP_DELETE, '0, '0, '0));
    send_beat(make_req(OP_APPEND, key_a, 16'h0101, '0));
    send_beat(make_req(OP_APPEND, key_b, 16'h0202, '0));
    // The first hit moves B to the front; more hits keep it there.
    repeat (4) send_beat(make_req(OP_LOOKUP, key_b, 16'h0202, '0));
    // A draws level with B but does not pass it, so it stays second.
    repeat (4) send_beat(make_req(OP_LOOKUP, key_a, 16'h0101, '0));
    send_beat(make_req(OP_EXISTS, key_a, 16'h0101, '0));
    // One more hit puts A ahead of B.
    send_beat(make_req(OP_LOOKUP, key_a, 16'h0101, '0));
    send_beat(make_req(OP_EXISTS, key_b, 16'h0202, '0));
  endtask

  // One random request; appends and deletes by the given percentages, the rest mostly searches.
  function automatic colt_req_t rand_request(int append_pct, int delete_pct);
    colt_req_t r;
    int        pick;
    int        slot;
    pick = $urandom_range(0, 99);
    if (pick < append_pct)
      r.req_type = OP_APPEND;
    else if (pick < append_pct + delete_pct)
      r.req_type = OP_DELETE;
    else begin
      case (pick % 20) inside
        [0:8]:       r.req_type = OP_LOOKUP;
        [9:12], 19:  r.req_type = OP_EXISTS;
        18:          r.req_type = 3'($urandom_range(5, 7));
        default:     r.req_type = OP_GET;
      endcase
    end

    // Key and length: an entry of the table, a near miss, a pool pair or noise.
    pick = $urandom_range(0, 99);
    if (r.req_type != OP_APPEND && tbl_used > 0 && pick < 60) begin
      slot          = $urandom_range(0, tbl_used - 1);
      r.item_key    = tbl_key[slot];
      r.item_length = tbl_len[slot];
      if (pick < 10) r.item_length ^= 16'(1 << $urandom_range(0, 15));
    end else if (pick < 85) begin
      slot          = $urandom_range(0, 7);
      r.item_key    = key_pool[slot];
      r.item_length = len_pool[slot];
    end else begin
      r.item_key    = $urandom();
      r.item_length = 16'($urandom());
    end

    // Index: mostly in range, sometimes anywhere.
    if (tbl_used > 0 && $urandom_range(0, 9) < 7)
      r.entry_index = 4'($urandom_range(0, tbl_used - 1));
    else
      r.entry_index = 4'($urandom_range(0, 15));
    return r;
  endfunction

  task automatic test_random_mix(int n, int append_pct, int delete_pct);
    repeat (n) send_paced(rand_request(append_pct, delete_pct));
  endtask

  // Sequence of tests.
  initial begin
    int i;
    err_count  = 0;
    burst_left = 0;
    tbl_used   = 0;
    for (i = 0; i < 8; i++) begin
      key_pool[i] = $urandom();
      len_pool[i] = 16'($urandom());
    end
    key_pool[0] = '0;
    len_pool[0] = '1;
    key_pool[1] = '1;
    len_pool[1] = '0;

    rst   <= 1'b1;
    start <= 1'b0;
    req   <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_empty_table();
    test_fill_to_full();
    test_hits_and_removal();
    test_promotion_order();
    test_random_mix(250, 45, 10);
    test_random_mix(250, 15, 35);
    test_random_mix(250, 30, 30);

    // Let the last results come out, then idle before the report.
    start <= 1'b0;
    while (rsp_owed_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+sv
sv/colt_pkg.sv
sv/colt_ctrl.sv
sv/colt_dp.sv
sv/count_ordered_lookup_table.sv
dv/tb_count_ordered_lookup_table.sv
